/* sv/bsi_pkg.sv */
package bsi_pkg;

    // Sections the design is built for; the section field is five bits wide,
    // so no more than 32 of them can be named.
    localparam int NUM_SECTIONS = 32;
    localparam int SECT_LIMIT   = (NUM_SECTIONS < 32) ? NUM_SECTIONS : 32;

    localparam logic [2:0] OP_START    = 3'd0;
    localparam logic [2:0] OP_CROSSING = 3'd1;
    localparam logic [2:0] OP_ENTRY    = 3'd2;
    localparam logic [2:0] OP_EXIT     = 3'd3;
    localparam logic [2:0] OP_REQUEST  = 3'd4;
    localparam logic [2:0] OP_CANCEL   = 3'd5;

    localparam logic [1:0] KIND_PERMIT   = 2'd0;
    localparam logic [1:0] KIND_PROHIBIT = 2'd1;
    localparam logic [1:0] KIND_ESTOP    = 2'd2;

    localparam logic [3:0] ERR_NONE              = 4'd0;
    localparam logic [3:0] ERR_RANGE             = 4'd1;
    localparam logic [3:0] ERR_CROSS_PENDING     = 4'd2;
    localparam logic [3:0] ERR_CROSS_OCCUPIED    = 4'd3;
    localparam logic [3:0] ERR_CROSS_NO_TRAIN    = 4'd4;
    localparam logic [3:0] ERR_ENTRY_NO_REQUEST  = 4'd5;
    localparam logic [3:0] ERR_ENTRY_OCCUPIED    = 4'd6;
    localparam logic [3:0] ERR_EXIT_NO_POINT     = 4'd7;
    localparam logic [3:0] ERR_EXIT_EMPTY        = 4'd8;
    localparam logic [3:0] ERR_REQ_NO_POINT      = 4'd9;
    localparam logic [3:0] ERR_REQ_OCCUPIED      = 4'd10;
    localparam logic [3:0] ERR_REQ_PREV_OCCUPIED = 4'd11;
    localparam logic [3:0] ERR_CAN_NO_POINT      = 4'd12;
    localparam logic [3:0] ERR_CAN_NO_REQUEST    = 4'd13;
    localparam logic [3:0] ERR_CAN_OCCUPIED      = 4'd14;

    localparam logic [1:0] CFG_SECTION_COUNT     = 2'd0;
    localparam logic [1:0] CFG_ENTRY_MASK        = 2'd1;
    localparam logic [1:0] CFG_INITIAL_OCCUPANCY = 2'd2;

    typedef struct packed {
        logic [2:0] op;
        logic [4:0] section;
    } t_in;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] target_section;
        logic [3:0] error_code;
        logic       granted;
        logic       estop_latched;
        logic       last;
    } t_out;

    typedef struct packed {
        logic load;
        logic exec;
        logic second;
        logic range_step;
        logic scan_step;
    } t_cmd;

    typedef struct packed {
        logic start_op;
        logic range_hit;
        logic range_done;
        logic scan_done;
        logic two;
    } t_stat;

endpackage

/* sv/bsi_ctrl.sv */
module bsi_ctrl
    import bsi_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SECOND,
        S_RANGE,
        S_SCAN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.start_op ? S_RANGE : S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.two ? S_SECOND : S_IDLE;
            end
            S_SECOND: begin
                o_cmd.second = 1'b1;
                n_state      = S_IDLE;
            end
            S_RANGE: begin
                o_cmd.range_step = 1'b1;
                if (i_stat.range_hit) begin
                    n_state = S_IDLE;
                end else if (i_stat.range_done) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted event did not make the block busy");

    a_exec_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_state == S_IDLE || r_state == S_SECOND))
        else $error("single event took an unexpected path");

    a_second_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SECOND) |=> (r_state == S_IDLE))
        else $error("second notice did not end the event");

endmodule

/* sv/bsi_dpath.sv */
module bsi_dpath
    import bsi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    input  t_in         i_in,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic        o_valid,
    output t_out        o_out
);

    logic [5:0]  r_section_count;
    logic [31:0] r_entry_mask;
    logic [31:0] r_init_occ;
    logic [31:0] r_occ;
    logic [31:0] r_pend;
    logic        r_estop;
    logic [2:0]  r_op;
    logic [4:0]  r_sec;
    logic [4:0]  r_prev;
    logic [5:0]  r_idx;
    logic [31:0] r_scan;
    logic        r_valid;
    logic        n_valid;
    t_out        r_out;

    logic [5:0]  eff_n;
    logic [31:0] in_use;
    logic        in_range;
    logic [4:0]  prev;
    logic        has_entry;
    logic        occ_s;
    logic        occ_p;
    logic        pend_s;
    logic [31:0] sbit;
    logic [31:0] pbit;
    logic        e_valid;
    logic        e_two;
    logic [1:0]  e_kind;
    logic [3:0]  e_code;
    logic        e_granted;
    logic [31:0] e_occ;
    logic [31:0] e_pend;
    logic [31:0] idx_bit;
    logic [31:0] scan_left;
    logic [31:0] start_occ;

    always_comb begin
        if (r_section_count == 6'd0) begin
            eff_n = 6'd1;
        end else if (r_section_count > 6'(SECT_LIMIT)) begin
            eff_n = 6'(SECT_LIMIT);
        end else begin
            eff_n = r_section_count;
        end
    end

    assign in_use    = 32'((33'd1 << eff_n) - 33'd1);
    assign in_range  = ({1'b0, r_sec} < eff_n);
    assign prev      = (r_sec == 5'd0) ? 5'(eff_n - 6'd1) : r_sec - 5'd1;
    assign has_entry = r_entry_mask[r_sec];
    assign occ_s     = r_occ[r_sec];
    assign occ_p     = r_occ[prev];
    assign pend_s    = r_pend[r_sec];
    assign sbit      = 32'd1 << r_sec;
    assign pbit      = 32'd1 << prev;

    // Rules of one event, checked in the order of their error codes.
    always_comb begin
        e_valid   = 1'b1;
        e_two     = 1'b0;
        e_kind    = KIND_ESTOP;
        e_code    = ERR_NONE;
        e_granted = 1'b0;
        e_occ     = r_occ;
        e_pend    = r_pend;
        if (r_op > OP_CANCEL || r_op == OP_START) begin
            e_valid = 1'b0;
        end else if (!in_range) begin
            e_code = ERR_RANGE;
        end else begin
            case (r_op)
                OP_CROSSING: begin
                    if (has_entry && pend_s) begin
                        e_code = ERR_CROSS_PENDING;
                    end else if (occ_s) begin
                        e_code = ERR_CROSS_OCCUPIED;
                    end else if (!occ_p) begin
                        e_code = ERR_CROSS_NO_TRAIN;
                    end else begin
                        e_kind = KIND_PROHIBIT;
                        e_two  = 1'b1;
                        e_occ  = (r_occ | sbit) & ~pbit;
                    end
                end
                OP_ENTRY: begin
                    if (!pend_s) begin
                        e_code = ERR_ENTRY_NO_REQUEST;
                    end else if (occ_s) begin
                        e_code = ERR_ENTRY_OCCUPIED;
                    end else begin
                        e_kind = KIND_PROHIBIT;
                        e_pend = r_pend & ~sbit;
                        e_occ  = r_occ | sbit;
                    end
                end
                OP_EXIT: begin
                    if (!has_entry) begin
                        e_code = ERR_EXIT_NO_POINT;
                    end else if (!occ_s) begin
                        e_code = ERR_EXIT_EMPTY;
                    end else begin
                        e_kind = KIND_PERMIT;
                        e_occ  = r_occ & ~sbit;
                        e_pend = r_pend & ~sbit;
                    end
                end
                OP_REQUEST: begin
                    if (!has_entry) begin
                        e_code = ERR_REQ_NO_POINT;
                    end else if (occ_s) begin
                        e_code = ERR_REQ_OCCUPIED;
                    end else if (occ_p) begin
                        e_code = ERR_REQ_PREV_OCCUPIED;
                    end else begin
                        e_kind    = KIND_PROHIBIT;
                        e_granted = 1'b1;
                        e_pend    = r_pend | sbit;
                    end
                end
                default: begin
                    if (!has_entry) begin
                        e_code = ERR_CAN_NO_POINT;
                    end else if (!pend_s) begin
                        e_code = ERR_CAN_NO_REQUEST;
                    end else if (occ_s) begin
                        e_code = ERR_CAN_OCCUPIED;
                    end else begin
                        e_kind = KIND_PERMIT;
                        e_pend = r_pend & ~sbit;
                    end
                end
            endcase
        end
    end

    assign idx_bit   = 32'd1 << r_idx[4:0];
    assign scan_left = r_scan & ~idx_bit;
    assign start_occ = r_occ | r_init_occ;

    always_comb begin
        o_stat            = '0;
        o_stat.start_op   = (i_in.op == OP_START);
        o_stat.range_done = r_idx[5];
        o_stat.range_hit  = !r_idx[5] && r_init_occ[r_idx[4:0]];
        o_stat.scan_done  = (scan_left == 32'd0);
        o_stat.two        = e_two;
    end

    assign n_valid = (i_cmd.exec && e_valid) || i_cmd.second
                     || (i_cmd.range_step && !r_idx[5] && r_init_occ[r_idx[4:0]])
                     || (i_cmd.scan_step && r_scan[r_idx[4:0]]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_section_count <= 6'(SECT_LIMIT);
            r_entry_mask    <= '0;
            r_init_occ      <= '0;
            r_occ           <= '0;
            r_pend          <= '0;
            r_estop         <= 1'b0;
            r_valid         <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SECTION_COUNT:     r_section_count <= i_cfg_wdata[5:0];
                    CFG_ENTRY_MASK:        r_entry_mask    <= i_cfg_wdata;
                    CFG_INITIAL_OCCUPANCY: r_init_occ      <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.exec) begin
                r_occ   <= e_occ;
                r_pend  <= e_pend;
                if (e_valid && e_kind == KIND_ESTOP) begin
                    r_estop <= 1'b1;
                end
            end
            if (i_cmd.range_step && !r_idx[5] && r_init_occ[r_idx[4:0]]) begin
                r_estop <= 1'b1;
            end
            if (i_cmd.range_step && r_idx[5]) begin
                r_occ <= start_occ;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_in.op;
            r_sec <= i_in.section;
            r_idx <= eff_n;
        end
        if (i_cmd.exec) begin
            r_prev                 <= prev;
            r_out.kind             <= e_kind;
            r_out.target_section   <= r_sec;
            r_out.error_code       <= e_code;
            r_out.granted          <= e_granted;
            r_out.estop_latched    <= r_estop || (e_kind == KIND_ESTOP);
            r_out.last             <= !e_two;
        end
        if (i_cmd.second) begin
            r_out.kind           <= KIND_PERMIT;
            r_out.target_section <= r_prev;
            r_out.error_code     <= ERR_NONE;
            r_out.granted        <= 1'b0;
            r_out.estop_latched  <= r_estop;
            r_out.last           <= 1'b1;
        end
        if (i_cmd.range_step) begin
            if (r_idx[5]) begin
                // Out-of-range walk passed; start the permit walk from section zero.
                r_scan <= ~start_occ & in_use;
                r_idx  <= 6'd0;
            end else begin
                r_idx                <= r_idx + 6'd1;
                r_out.kind           <= KIND_ESTOP;
                r_out.target_section <= r_idx[4:0];
                r_out.error_code     <= ERR_RANGE;
                r_out.granted        <= 1'b0;
                r_out.estop_latched  <= 1'b1;
                r_out.last           <= 1'b1;
            end
        end
        if (i_cmd.scan_step) begin
            r_idx                <= r_idx + 6'd1;
            r_scan               <= scan_left;
            r_out.kind           <= KIND_PERMIT;
            r_out.target_section <= r_idx[4:0];
            r_out.error_code     <= ERR_NONE;
            r_out.granted        <= 1'b0;
            r_out.estop_latched  <= r_estop;
            r_out.last           <= (scan_left == 32'd0);
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

    a_estop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_out.kind == KIND_ESTOP) |-> (r_out.last && r_out.estop_latched))
        else $error("estop beat must be final and carry the latched flag");

    a_estop_sticky: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n) && $past(r_estop)) |-> r_estop)
        else $error("estop flag cleared outside reset");

    a_grant_prohibit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_out.granted) |-> (r_out.kind == KIND_PROHIBIT && r_out.last))
        else $error("grant on a beat that is not a final prohibit notice");

endmodule

/* sv/block_signal_interlock_top.sv */
// Single events: accepted at one edge, executed in the next cycle, result beat in the cycle
// after that; busy drops with the final beat, and a crossing adds a second beat for the section behind.
// Start: one cycle per section from the section count up to 31 for the range walk (ending
// at the first hit), then the occupancy is taken, then one cycle per section up to the
// last empty one for the permit walk, each permit a beat of its own.
// Results are strobed for one cycle on o_valid; the receiver cannot stall.
// Synchronous active-low reset clears occupancy, pending entries, estop, masks; 32 sections.
module block_signal_interlock_top
    import bsi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_start,
    input  t_in         i_in,
    output logic        o_busy,
    output logic        o_valid,
    output t_out        o_out
);

    t_cmd  cmd;
    t_stat stat;

    bsi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    bsi_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_valid     (o_valid),
        .o_out       (o_out)
    );

endmodule

/* sim/interlock_notice_check.sv */
`timescale 1ns / 1ps

module interlock_notice_check
    import bsi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_start,
    input  logic        i_busy,
    input  t_in         i_in,
    input  logic        i_valid,
    input  t_out        i_out,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_beats
);

    logic [5:0]  count_reg;
    logic [31:0] mask_reg;
    logic [31:0] init_reg;
    logic [31:0] occupied;
    logic [31:0] entry_waiting;
    logic        estop;

    t_out notice_q[$];
    t_out held;
    logic have_held;
    t_out expected;
    logic bad;
    int   reported;

    function automatic int unsigned live_sections();
        int unsigned c;
        c = count_reg;
        if (c < 1) c = 1;
        if (c > SECT_LIMIT) c = SECT_LIMIT;
        return c;
    endfunction

    // The newest notice is held back so that the final one of an event can be marked last.
    task automatic queue_notice(input logic [1:0] nk, input logic [4:0] sect,
                                input logic [3:0] code, input logic grant);
        if (have_held) notice_q.push_back(held);
        held.kind           = nk;
        held.target_section = sect;
        held.error_code     = code;
        held.granted        = grant;
        held.estop_latched  = estop;
        held.last           = 1'b0;
        have_held           = 1'b1;
    endtask

    task automatic raise_estop(input logic [4:0] sect, input logic [3:0] code);
        estop = 1'b1;
        queue_notice(KIND_ESTOP, sect, code, 1'b0);
    endtask

    task automatic predict_event(input t_in ev);
        int unsigned n;
        int unsigned prev;
        int unsigned i;
        logic [4:0]  s;
        logic        has;
        logic        done;
        n         = live_sections();
        s         = ev.section;
        has       = mask_reg[s];
        have_held = 1'b0;
        if (ev.op == OP_START) begin
            done = 1'b0;
            for (i = n; i < 32; i++) begin
                if (!done && init_reg[i]) begin
                    raise_estop(i[4:0], ERR_RANGE);
                    done = 1'b1;
                end
            end
            if (!done) begin
                occupied |= init_reg;
                for (i = 0; i < n; i++) begin
                    if (!occupied[i]) queue_notice(KIND_PERMIT, i[4:0], ERR_NONE, 1'b0);
                end
            end
        end else if (ev.op > OP_CANCEL) begin
            // Unused codes leave everything as it is.
        end else if (s >= n) begin
            raise_estop(s, ERR_RANGE);
        end else begin
            prev = (s == 0) ? n - 1 : s - 1;
            case (ev.op)
                OP_CROSSING: begin
                    if (has && entry_waiting[s]) raise_estop(s, ERR_CROSS_PENDING);
                    else if (occupied[s]) raise_estop(s, ERR_CROSS_OCCUPIED);
                    else if (!occupied[prev]) raise_estop(s, ERR_CROSS_NO_TRAIN);
                    else begin
                        occupied[s]    = 1'b1;
                        occupied[prev] = 1'b0;
                        queue_notice(KIND_PROHIBIT, s, ERR_NONE, 1'b0);
                        queue_notice(KIND_PERMIT, prev[4:0], ERR_NONE, 1'b0);
                    end
                end
                OP_ENTRY: begin
                    if (!entry_waiting[s]) raise_estop(s, ERR_ENTRY_NO_REQUEST);
                    else if (occupied[s]) raise_estop(s, ERR_ENTRY_OCCUPIED);
                    else begin
                        entry_waiting[s] = 1'b0;
                        occupied[s]      = 1'b1;
                        queue_notice(KIND_PROHIBIT, s, ERR_NONE, 1'b0);
                    end
                end
                OP_EXIT: begin
                    if (!has) raise_estop(s, ERR_EXIT_NO_POINT);
                    else if (!occupied[s]) raise_estop(s, ERR_EXIT_EMPTY);
                    else begin
                        occupied[s]      = 1'b0;
                        entry_waiting[s] = 1'b0;
                        queue_notice(KIND_PERMIT, s, ERR_NONE, 1'b0);
                    end
                end
                OP_REQUEST: begin
                    if (!has) raise_estop(s, ERR_REQ_NO_POINT);
                    else if (occupied[s]) raise_estop(s, ERR_REQ_OCCUPIED);
                    else if (occupied[prev]) raise_estop(s, ERR_REQ_PREV_OCCUPIED);
                    else begin
                        entry_waiting[s] = 1'b1;
                        queue_notice(KIND_PROHIBIT, s, ERR_NONE, 1'b1);
                    end
                end
                default: begin
                    if (!has) raise_estop(s, ERR_CAN_NO_POINT);
                    else if (!entry_waiting[s]) raise_estop(s, ERR_CAN_NO_REQUEST);
                    else if (occupied[s]) raise_estop(s, ERR_CAN_OCCUPIED);
                    else begin
                        entry_waiting[s] = 1'b0;
                        queue_notice(KIND_PERMIT, s, ERR_NONE, 1'b0);
                    end
                end
            endcase
        end
        if (have_held) begin
            held.last = 1'b1;
            notice_q.push_back(held);
            have_held = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            count_reg     = 6'd32;
            mask_reg      = '0;
            init_reg      = '0;
            occupied      = '0;
            entry_waiting = '0;
            estop         = 1'b0;
            have_held     = 1'b0;
            notice_q.delete();
            o_fail_count  = 0;
            o_beats       = 0;
            reported      = 0;
        end else begin
            // Results are retired before new events are predicted, so a beat of an older
            // event meets its own expectation when both happen at one edge.
            if (i_valid) begin
                o_beats++;
                if (notice_q.size() == 0) begin
                    if (reported < 10) begin
                        $display("unexpected beat: kind=%0d sect=%0d err=%0d gr=%0d es=%0d last=%0d",
                                 i_out.kind, i_out.target_section, i_out.error_code,
                                 i_out.granted, i_out.estop_latched, i_out.last);
                    end
                    reported++;
                    o_fail_count++;
                end else begin
                    expected = notice_q.pop_front();
                    bad = (i_out.kind !== expected.kind) ||
                          (i_out.target_section !== expected.target_section) ||
                          (i_out.error_code !== expected.error_code) ||
                          (i_out.granted !== expected.granted) ||
                          (i_out.estop_latched !== expected.estop_latched) ||
                          (i_out.last !== expected.last);
                    if (bad) begin
                        if (reported < 10) begin
                            $display("mismatch: expected kind=%0d sect=%0d err=%0d gr=%0d es=%0d last=%0d",
                                     expected.kind, expected.target_section,
                                     expected.error_code, expected.granted,
                                     expected.estop_latched, expected.last);
                            $display("          actual   kind=%0d sect=%0d err=%0d gr=%0d es=%0d last=%0d",
                                     i_out.kind, i_out.target_section, i_out.error_code,
                                     i_out.granted, i_out.estop_latched, i_out.last);
                        end
                        reported++;
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SECTION_COUNT:     count_reg = i_cfg_wdata[5:0];
                    CFG_ENTRY_MASK:        mask_reg  = i_cfg_wdata;
                    CFG_INITIAL_OCCUPANCY: init_reg  = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) predict_event(i_in);
        end
        o_pending = notice_q.size();
    end

endmodule

/* sim/block_signal_interlock_top_tb.sv */
`timescale 1ns / 1ps

module block_signal_interlock_top_tb;
    import bsi_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 80;
    localparam int RANDOM_EVENTS = 370;
    localparam int PHASES        = 8;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_idx   = '0;
    logic [31:0] cfg_wdata = '0;
    logic        start_q   = 1'b0;
    t_in         ev_q      = '0;
    logic        busy;
    logic        valid;
    t_out        notice;

    int          fail_count;
    int          pending;
    int          beats;
    int          cycles      = 0;
    int          events_sent = 0;
    int          phases_run  = 0;
    int          cur_count   = 32;
    logic [31:0] cur_mask    = '0;
    logic        busy_seen   = 1'b0;
    logic        burst       = 1'b0;

    int          phase;
    int          target;
    logic [5:0]  ph_count;
    logic [31:0] ph_mask;
    logic [31:0] ph_init;

    block_signal_interlock_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_start     (start_q),
        .i_in        (ev_q),
        .o_busy      (busy),
        .o_valid     (valid),
        .o_out       (notice)
    );

    interlock_notice_check u_notice_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .i_start      (start_q),
        .i_busy       (busy),
        .i_in         (ev_q),
        .i_valid      (valid),
        .i_out        (notice),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_beats      (beats)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Busy is taken mid-cycle so the driver knows, at the next edge, whether the beat went in.
    always @(negedge clk) begin
        busy_seen = busy;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic configure(input logic [5:0] cnt, input logic [31:0] mask,
                             input logic [31:0] init_occ);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(CFG_SECTION_COUNT, {junk[31:6], cnt});
        write_reg(CFG_ENTRY_MASK, mask);
        write_reg(CFG_INITIAL_OCCUPANCY, init_occ);
        cfg_we    <= 1'b0;
        cur_count = (cnt == 0) ? 1 : ((cnt > SECT_LIMIT) ? SECT_LIMIT : int'(cnt));
        cur_mask  = mask;
        phases_run++;
    endtask

    // A start with every section filled gives no beat, so a fixed pause follows the drain.
    task automatic wait_idle();
        start_q <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_event(input logic [2:0] op, input logic [4:0] sect);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            start_q <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start_q <= 1'b1;
        ev_q    <= {op, sect};
        do @(posedge clk); while (busy_seen);
        if (op <= OP_CANCEL) events_sent++;
    endtask

    function automatic logic [4:0] step_section(input logic [4:0] s);
        return (s + 1 >= cur_count) ? 5'd0 : s + 5'd1;
    endfunction

    // A train enters at an entry point, runs a few sections and leaves at the next exit.
    task automatic run_journey();
        logic [4:0] s;
        int         k;
        s = 5'($urandom_range(0, cur_count - 1));
        for (k = 0; k < cur_count && !cur_mask[s]; k++) s = step_section(s);
        send_event(OP_REQUEST, s);
        if ($urandom_range(0, 4) == 0) begin
            send_event(OP_CANCEL, s);
        end else begin
            send_event(OP_ENTRY, s);
            repeat ($urandom_range(1, 4)) begin
                s = step_section(s);
                send_event(OP_CROSSING, s);
            end
            for (k = 0; k < cur_count && !cur_mask[s]; k++) begin
                s = step_section(s);
                send_event(OP_CROSSING, s);
            end
            send_event(OP_EXIT, s);
        end
    endtask

    task automatic noise_event();
        logic [2:0] op;
        logic [4:0] sect;
        op = 3'($urandom_range(0, 7));
        if (op == OP_START && $urandom_range(0, 2) != 0) op = OP_CROSSING;
        if ($urandom_range(0, 4) == 0) sect = 5'($urandom_range(0, 31));
        else sect = 5'($urandom_range(0, cur_count - 1));
        send_event(op, sect);
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: a start gives a permit for all 32 sections.
        send_event(OP_START, 5'd17);
        send_event(OP_CROSSING, 5'd31);
        wait_idle();

        configure(6'd4, 32'h0000_0005, 32'h0000_0001);
        send_event(OP_START, 5'd0);
        send_event(OP_CROSSING, 5'd1);
        send_event(OP_CROSSING, 5'd1);
        send_event(OP_CROSSING, 5'd3);
        send_event(OP_REQUEST, 5'd2);
        send_event(OP_REQUEST, 5'd0);
        send_event(OP_CROSSING, 5'd0);
        send_event(OP_ENTRY, 5'd0);
        send_event(OP_ENTRY, 5'd0);
        send_event(OP_REQUEST, 5'd1);
        send_event(OP_REQUEST, 5'd0);
        send_event(OP_EXIT, 5'd1);
        send_event(OP_EXIT, 5'd2);
        send_event(OP_EXIT, 5'd0);
        send_event(OP_CANCEL, 5'd1);
        send_event(OP_CANCEL, 5'd0);
        send_event(OP_REQUEST, 5'd0);
        send_event(OP_CANCEL, 5'd0);
        send_event(OP_REQUEST, 5'd0);
        // A start while an entry is pending fills that section under the request.
        send_event(OP_START, 5'd0);
        send_event(OP_ENTRY, 5'd0);
        send_event(OP_CANCEL, 5'd0);
        send_event(OP_CROSSING, 5'd5);
        send_event(3'd6, 5'd0);
        send_event(3'd7, 5'd31);
        wait_idle();

        configure(6'd4, 32'h0000_0005, 32'h8000_0000);
        send_event(OP_START, 5'd0);

        for (phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    ph_count = 6'd32;
                    ph_mask  = 32'hFFFF_FFFF;
                    ph_init  = $urandom;
                end
                1: begin
                    ph_count = 6'd0;
                    ph_mask  = $urandom;
                    ph_init  = 32'h0000_0001;
                end
                2: begin
                    ph_count = 6'd63;
                    ph_mask  = 32'h0000_0000;
                    ph_init  = 32'h0000_0000;
                end
                3: begin
                    ph_count = 6'd2;
                    ph_mask  = 32'h0000_0003;
                    ph_init  = $urandom & 32'h0000_0003;
                end
                4: begin
                    ph_count = 6'd32;
                    ph_mask  = $urandom;
                    ph_init  = 32'hFFFF_FFFF;
                end
                default: begin
                    ph_count = 6'($urandom_range(3, 31));
                    ph_mask  = $urandom;
                    ph_init  = $urandom;
                    if ($urandom_range(0, 3) != 0) ph_init &= (32'h1 << ph_count) - 32'h1;
                end
            endcase
            configure(ph_count, ph_mask, ph_init);
            target = events_sent + RANDOM_EVENTS / PHASES;
            while (events_sent < target) begin
                if ($urandom_range(0, 15) == 0) burst = !burst;
                if ($urandom_range(0, 9) < 7) run_journey();
                else noise_event();
            end
        end

        wait_idle();
        @(negedge clk);
        $display("ran %0d track events over %0d register settings", events_sent, phases_run);
        $display("compared %0d result beats, %0d failures", beats, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
